### rtl/core/sem_pkg.sv
`timescale 1ns / 1ps

package sem_pkg;

    localparam int NUM_CH   = 3;
    localparam int CH_W     = 8;
    localparam int PIX_W    = NUM_CH * CH_W;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 2 * GRAD_W;
    localparam int SUM_W    = 16;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int ROW_W    = 13;
    localparam int IWIDTH_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Largest sum whose rounded root still fits in eight bits.
    localparam int SAT_LIMIT = 65280;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [IWIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_W-1:0]    HEIGHT_RESET = 13'd768;

    typedef logic [PIX_W-1:0] sem_pix_t;
    typedef sem_pix_t [8:0] sem_win_t;

    typedef struct packed {
        logic             sat;
        logic [SUM_W-1:0] sum;
    } sem_sq_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX_RD,
        ST_DR_ADDR,
        ST_DR_DATA,
        ST_EVAL,
        ST_SQR,
        ST_GO,
        ST_ROOT
    } sem_state_t;

endpackage

### rtl/core/sem_ram.sv
`timescale 1ns / 1ps

module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/sem_grad.sv
`timescale 1ns / 1ps

module sem_grad (
    input  logic                                    aclk,
    input  sem_pkg::sem_win_t                       win,
    output sem_pkg::sem_sq_t [sem_pkg::NUM_CH-1:0]  sq
);

    logic signed [sem_pkg::GRAD_W-1:0] gx_reg [sem_pkg::NUM_CH];
    logic signed [sem_pkg::GRAD_W-1:0] gy_reg [sem_pkg::NUM_CH];
    logic signed [sem_pkg::GRAD_W-1:0] gx_next [sem_pkg::NUM_CH];
    logic signed [sem_pkg::GRAD_W-1:0] gy_next [sem_pkg::NUM_CH];
    sem_pkg::sem_sq_t [sem_pkg::NUM_CH-1:0] sq_reg;
    sem_pkg::sem_sq_t [sem_pkg::NUM_CH-1:0] sq_next;

    logic [sem_pkg::GRAD_W-1:0] v [sem_pkg::NUM_CH][9];
    logic [sem_pkg::GRAD_W-1:0] px [sem_pkg::NUM_CH];
    logic [sem_pkg::GRAD_W-1:0] nx [sem_pkg::NUM_CH];
    logic [sem_pkg::GRAD_W-1:0] py [sem_pkg::NUM_CH];
    logic [sem_pkg::GRAD_W-1:0] ny [sem_pkg::NUM_CH];
    logic signed [sem_pkg::SQ_W-1:0] sqx [sem_pkg::NUM_CH];
    logic signed [sem_pkg::SQ_W-1:0] sqy [sem_pkg::NUM_CH];
    logic [sem_pkg::SQ_W-1:0] sum [sem_pkg::NUM_CH];

    // First stage: Sobel sums per channel. Each signed side stays below 1024.
    always_comb begin
        for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
            for (int k = 0; k < 9; k++) begin
                v[ch][k] = sem_pkg::GRAD_W'(win[k][ch*sem_pkg::CH_W +: sem_pkg::CH_W]);
            end
            px[ch] = v[ch][2] + (v[ch][5] << 1) + v[ch][8];
            nx[ch] = v[ch][0] + (v[ch][3] << 1) + v[ch][6];
            py[ch] = v[ch][6] + (v[ch][7] << 1) + v[ch][8];
            ny[ch] = v[ch][0] + (v[ch][1] << 1) + v[ch][2];
            gx_next[ch] = $signed(px[ch] - nx[ch]);
            gy_next[ch] = $signed(py[ch] - ny[ch]);
        end
    end

    // Second stage: squared magnitude, saturated where the root would pass 255.
    always_comb begin
        for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
            sqx[ch] = gx_reg[ch] * gx_reg[ch];
            sqy[ch] = gy_reg[ch] * gy_reg[ch];
            sum[ch] = $unsigned(sqx[ch]) + $unsigned(sqy[ch]);
            sq_next[ch].sat = sum[ch] > sem_pkg::SQ_W'(sem_pkg::SAT_LIMIT);
            sq_next[ch].sum = sum[ch][sem_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
            gx_reg[ch] <= gx_next[ch];
            gy_reg[ch] <= gy_next[ch];
        end
        sq_reg <= sq_next;
    end

    assign sq = sq_reg;

endmodule

### rtl/core/sem_root.sv
`timescale 1ns / 1ps

module sem_root (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  sem_pkg::sem_sq_t            sq_in,
    output logic                        done,
    output logic [sem_pkg::ROOT_W-1:0]  mag
);

    localparam int STEP_W = $clog2(sem_pkg::ROOT_W);
    localparam int REM_W  = sem_pkg::ROOT_W + 1;
    localparam int TRY_W  = REM_W + 2;

    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [sem_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [sem_pkg::ROOT_W-1:0] q_reg, q_next;
    logic                       sat_reg, sat_next;

    logic [TRY_W-1:0] rem_sh;
    logic [TRY_W-1:0] trial;
    logic             round_up;

    // Restoring square root, two radicand bits in and one root bit out per cycle.
    // The remainder never exceeds twice the partial root, so it fits in REM_W bits.
    always_comb begin
        run_next  = run_reg;
        done_next = done_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        rem_sh    = {rem_reg, acc_reg[sem_pkg::SUM_W-1 -: 2]};
        trial     = {1'b0, q_reg, 2'b01};
        if (start) begin
            run_next  = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            acc_next  = sq_in.sum;
            rem_next  = '0;
            q_next    = '0;
            sat_next  = sq_in.sat;
        end else if (run_reg) begin
            acc_next = acc_reg << 2;
            if (rem_sh >= trial) begin
                rem_next = REM_W'(rem_sh - trial);
                q_next   = {q_reg[sem_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next = REM_W'(rem_sh);
                q_next   = {q_reg[sem_pkg::ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(sem_pkg::ROOT_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    // With s = q*q + rem, rounding up is needed exactly when rem > q.
    assign round_up = rem_reg > REM_W'(q_reg);
    assign done     = done_reg;
    assign mag      = sat_reg ? '1 : q_reg + sem_pkg::ROOT_W'(round_up);

endmodule

### rtl/core/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                Payload
// s_       in         s_tvalid / s_tready      s_tdata: red_in, green_in, blue_in; s_tuser: cmd
// m_       out        m_tvalid / m_tready      m_tdata: red, green, blue edge;
//                                              m_tlast: last_of_run; m_tuser: frame_done
// cfg_     in         cfg_we                   cfg_index, cfg_wdata
//
// One input transaction is taken at a time. A pixel is read from the line buffers, and
// a drain item fetches three buffer columns. Each result then passes through gradient,
// square, root load, the bit-serial square root and the load into the output register.
// A pixel item thus yields no, one or two results.
// Reset is synchronous and active low; the line buffers are not cleared.
// A stalled output holds the finished root until the output register is free.

module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red_in, green_in, blue_in
    input  logic                            s_tuser,   // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // red_edge, green_edge, blue_edge
    output logic                            m_tlast,
    output logic                            m_tuser,   // frame_done
    input  logic                            cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WX    = (COL_W + 1 > sem_pkg::IWIDTH_W) ? COL_W + 1 : sem_pkg::IWIDTH_W;

    sem_pkg::sem_state_t state_reg, state_next;

    logic [sem_pkg::IWIDTH_W-1:0] width_reg, width_next;
    logic [sem_pkg::ROW_W-1:0]    height_reg, height_next;
    logic [sem_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [COL_W-1:0]             drain_reg, drain_next;
    logic [1:0]                   dcnt_reg, dcnt_next;
    logic                         cur_shift_reg, cur_shift_next;
    logic                         cur_last_reg, cur_last_next;
    logic                         cur_done_reg, cur_done_next;
    logic                         second_reg, second_next;
    sem_pkg::sem_pix_t            pix_reg, pix_next;
    sem_pkg::sem_win_t            win_reg, win_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [23:0]                  m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;
    logic                         m_tuser_reg, m_tuser_next;

    logic [WX-1:0]             width_x, max_x, w_eff, col_x, drain_x;
    logic [sem_pkg::ROW_W-1:0] h_eff;
    logic                      row_end, pix_ok, drain_ok, drain_last;
    logic [WX:0]               cx;
    logic                      c_ok;
    logic [COL_W-1:0]          c_addr;

    logic [COL_W-1:0]  rd_addr;
    logic              up_we, mid_we;
    sem_pkg::sem_pix_t up_q, mid_q, top_pix, mid_pix;
    sem_pkg::sem_win_t eval_win;
    sem_pkg::sem_sq_t [sem_pkg::NUM_CH-1:0] sq;
    logic [sem_pkg::NUM_CH-1:0] root_done;
    logic [sem_pkg::ROOT_W-1:0] mag [sem_pkg::NUM_CH];
    logic              root_start;
    logic              out_free;

    // Effective frame size: a zero width or height acts as one, a width above the
    // buffer depth acts as the depth.
    always_comb begin
        width_x = WX'(width_reg);
        max_x   = WX'(MAX_WIDTH);
        if (width_reg == '0) begin
            w_eff = WX'(1);
        end else if (width_x > max_x) begin
            w_eff = max_x;
        end else begin
            w_eff = width_x;
        end
        h_eff      = (height_reg == '0) ? sem_pkg::ROW_W'(1) : height_reg;
        col_x      = WX'(col_reg);
        drain_x    = WX'(drain_reg);
        row_end    = col_x == w_eff - WX'(1);
        pix_ok     = (row_reg < h_eff) && (col_x < w_eff);
        drain_ok   = (row_reg >= h_eff) && (drain_x < w_eff);
        drain_last = drain_x == w_eff - WX'(1);
        // Column fetched in this drain step is drain_reg + dcnt_reg - 1.
        cx     = {1'b0, drain_x} + (WX + 1)'(dcnt_reg);
        c_ok   = (cx != '0) && (cx <= {1'b0, w_eff});
        c_addr = COL_W'(cx - (WX + 1)'(1));
    end

    sem_ram #(
        .WIDTH (sem_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .aclk  (aclk),
        .we    (up_we),
        .waddr (col_reg),
        .wdata (mid_q),
        .raddr (rd_addr),
        .rdata (up_q)
    );

    sem_ram #(
        .WIDTH (sem_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .aclk  (aclk),
        .we    (mid_we),
        .waddr (col_reg),
        .wdata (pix_reg),
        .raddr (rd_addr),
        .rdata (mid_q)
    );

    // The row-end result sees the window moved one column left with zeros on the right.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (cur_shift_reg) begin
                eval_win[r*3]     = win_reg[r*3 + 1];
                eval_win[r*3 + 1] = win_reg[r*3 + 2];
                eval_win[r*3 + 2] = '0;
            end else begin
                eval_win[r*3]     = win_reg[r*3];
                eval_win[r*3 + 1] = win_reg[r*3 + 1];
                eval_win[r*3 + 2] = win_reg[r*3 + 2];
            end
        end
    end

    sem_grad u_grad (
        .aclk (aclk),
        .win  (eval_win),
        .sq   (sq)
    );

    for (genvar ch = 0; ch < sem_pkg::NUM_CH; ch++) begin : g_root
        sem_root u_root (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (root_start),
            .sq_in   (sq[ch]),
            .done    (root_done[ch]),
            .mag     (mag[ch])
        );
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        drain_next     = drain_reg;
        dcnt_next      = dcnt_reg;
        cur_shift_next = cur_shift_reg;
        cur_last_next  = cur_last_reg;
        cur_done_next  = cur_done_reg;
        second_next    = second_reg;
        pix_next       = pix_reg;
        win_next       = win_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;
        s_tready       = 1'b0;
        up_we          = 1'b0;
        mid_we         = 1'b0;
        rd_addr        = col_reg;
        root_start     = 1'b0;
        top_pix        = '0;
        mid_pix        = '0;

        unique case (state_reg)
            sem_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    pix_next = s_tdata;
                    if (s_tuser == sem_pkg::CMD_PIXEL) begin
                        if (pix_ok) begin
                            state_next = sem_pkg::ST_PIX_RD;
                        end
                    end else if (drain_ok) begin
                        dcnt_next  = '0;
                        state_next = sem_pkg::ST_DR_ADDR;
                    end
                end
            end

            sem_pkg::ST_PIX_RD: begin
                top_pix = (row_reg >= sem_pkg::ROW_W'(2)) ? up_q : '0;
                mid_pix = (row_reg != '0) ? mid_q : '0;
                for (int r = 0; r < 3; r++) begin
                    win_next[r*3]     = (col_reg == '0) ? '0 : win_reg[r*3 + 1];
                    win_next[r*3 + 1] = (col_reg == '0) ? '0 : win_reg[r*3 + 2];
                end
                win_next[2] = top_pix;
                win_next[5] = mid_pix;
                win_next[8] = pix_reg;
                up_we  = row_reg != '0;
                mid_we = 1'b1;
                if (row_end) begin
                    col_next = '0;
                    row_next = row_reg + sem_pkg::ROW_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
                state_next = sem_pkg::ST_IDLE;
                if (row_reg != '0) begin
                    cur_done_next = 1'b0;
                    if (col_reg != '0) begin
                        cur_shift_next = 1'b0;
                        cur_last_next  = !row_end;
                        second_next    = row_end;
                        state_next     = sem_pkg::ST_EVAL;
                    end else if (row_end) begin
                        cur_shift_next = 1'b1;
                        cur_last_next  = 1'b1;
                        second_next    = 1'b0;
                        state_next     = sem_pkg::ST_EVAL;
                    end
                end
            end

            sem_pkg::ST_DR_ADDR: begin
                rd_addr    = c_addr;
                state_next = sem_pkg::ST_DR_DATA;
            end

            sem_pkg::ST_DR_DATA: begin
                top_pix = (c_ok && h_eff >= sem_pkg::ROW_W'(2)) ? up_q : '0;
                mid_pix = c_ok ? mid_q : '0;
                for (int r = 0; r < 3; r++) begin
                    win_next[r*3]     = win_reg[r*3 + 1];
                    win_next[r*3 + 1] = win_reg[r*3 + 2];
                end
                win_next[2] = top_pix;
                win_next[5] = mid_pix;
                win_next[8] = '0;
                if (dcnt_reg == 2'd2) begin
                    cur_shift_next = 1'b0;
                    cur_last_next  = 1'b1;
                    cur_done_next  = drain_last;
                    second_next    = 1'b0;
                    if (drain_last) begin
                        row_next   = '0;
                        col_next   = '0;
                        drain_next = '0;
                    end else begin
                        drain_next = drain_reg + COL_W'(1);
                    end
                    state_next = sem_pkg::ST_EVAL;
                end else begin
                    dcnt_next  = dcnt_reg + 2'd1;
                    state_next = sem_pkg::ST_DR_ADDR;
                end
            end

            sem_pkg::ST_EVAL: begin
                state_next = sem_pkg::ST_SQR;
            end

            sem_pkg::ST_SQR: begin
                state_next = sem_pkg::ST_GO;
            end

            sem_pkg::ST_GO: begin
                root_start = 1'b1;
                state_next = sem_pkg::ST_ROOT;
            end

            sem_pkg::ST_ROOT: begin
                if (root_done[0] && out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {mag[2], mag[1], mag[0]};
                    m_tlast_next  = cur_last_reg;
                    m_tuser_next  = cur_done_reg;
                    if (second_reg) begin
                        second_next    = 1'b0;
                        cur_shift_next = 1'b1;
                        cur_last_next  = 1'b1;
                        cur_done_next  = 1'b0;
                        state_next     = sem_pkg::ST_EVAL;
                    end else begin
                        state_next = sem_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase

        // A write to the width or height register restarts the frame.
        if (cfg_we) begin
            priority case (cfg_index)
                sem_pkg::REG_IMAGE_WIDTH: begin
                    width_next = cfg_wdata[sem_pkg::IWIDTH_W-1:0];
                    row_next   = '0;
                    col_next   = '0;
                    drain_next = '0;
                end
                sem_pkg::REG_IMAGE_HEIGHT: begin
                    height_next = cfg_wdata[sem_pkg::ROW_W-1:0];
                    row_next    = '0;
                    col_next    = '0;
                    drain_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sem_pkg::ST_IDLE;
            width_reg     <= sem_pkg::WIDTH_RESET;
            height_reg    <= sem_pkg::HEIGHT_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            drain_reg     <= '0;
            dcnt_reg      <= '0;
            cur_shift_reg <= 1'b0;
            cur_last_reg  <= 1'b0;
            cur_done_reg  <= 1'b0;
            second_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            drain_reg     <= drain_next;
            dcnt_reg      <= dcnt_next;
            cur_shift_reg <= cur_shift_next;
            cur_last_reg  <= cur_last_next;
            cur_done_reg  <= cur_done_next;
            second_reg    <= second_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        pix_reg     <= pix_next;
        win_reg     <= win_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### sim/sobel_edge_checker.sv
`timescale 1ns / 1ps

module sobel_edge_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red_in, green_in, blue_in
    input  logic                            s_tuser,   // cmd
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [23:0]                     m_tdata,   // red_edge, green_edge, blue_edge
    input  logic                            m_tlast,
    input  logic                            m_tuser,   // frame_done
    input  logic                            cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              outstanding,
    output int                              mismatches
);
    import sem_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_run;
        logic       frame_done;
    } edge_result_t;

    edge_result_t pending_edges[$];

    // Pixels are kept as they travel on s_tdata: red in the low byte.
    sem_pix_t            upper_row  [MAX_WIDTH];
    sem_pix_t            middle_row [MAX_WIDTH];
    sem_win_t            window;
    logic [ROW_W-1:0]    row_cnt;
    logic [IWIDTH_W-1:0] col_cnt;
    logic [IWIDTH_W-1:0] drain_col;
    logic [IWIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]    height_reg;

    function automatic int active_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int active_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // Nearest integer root; no ties are possible, so r*r + r is the midpoint test.
    function automatic logic [7:0] rounded_root(int unsigned s);
        int unsigned r;
        r = 0;
        if (s > SAT_LIMIT) return 8'd255;
        while ((r + 1) * (r + 1) <= s) r++;
        if (s > r * r + r) r++;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic edge_result_t edge_of_window(sem_win_t w, logic last, logic done);
        edge_result_t res;
        int           v [9];
        int           gx;
        int           gy;
        logic [7:0]   mag [3];
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) v[k] = w[k][8*ch +: 8];
            gx = (v[2] - v[0]) + 2 * (v[5] - v[3]) + (v[8] - v[6]);
            gy = (v[6] + 2 * v[7] + v[8]) - (v[0] + 2 * v[1] + v[2]);
            mag[ch] = rounded_root(gx * gx + gy * gy);
        end
        res.red         = mag[0];
        res.green       = mag[1];
        res.blue        = mag[2];
        res.last_of_run = last;
        res.frame_done  = done;
        return res;
    endfunction

    task automatic restart_frame();
        window    = '0;
        row_cnt   = '0;
        col_cnt   = '0;
        drain_col = '0;
    endtask

    task automatic predict_pixel(sem_pix_t pix);
        int       w;
        int       h;
        int       j;
        int       r;
        sem_pix_t top;
        sem_pix_t mid;
        sem_win_t shifted;
        logic     row_end;
        w = active_width();
        h = active_height();
        j = col_cnt;
        r = row_cnt;
        if (r >= h || j >= w) return;
        if (j == 0) window = '0;
        top = (r >= 2) ? upper_row[j] : '0;
        mid = (r >= 1) ? middle_row[j] : '0;
        for (int k = 0; k < 3; k++) begin
            window[3*k]   = window[3*k+1];
            window[3*k+1] = window[3*k+2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = pix;
        if (r >= 1) upper_row[j] = mid;
        middle_row[j] = pix;
        if (r >= 1) begin
            row_end = (j == w - 1);
            if (j >= 1) pending_edges.push_back(edge_of_window(window, !row_end, 1'b0));
            // At the row end the last column of the row above is finished too,
            // with zeros standing in for the column past the edge.
            if (row_end) begin
                for (int k = 0; k < 3; k++) begin
                    shifted[3*k]   = window[3*k+1];
                    shifted[3*k+1] = window[3*k+2];
                    shifted[3*k+2] = '0;
                end
                pending_edges.push_back(edge_of_window(shifted, 1'b1, 1'b0));
            end
        end
        j++;
        if (j >= w) begin
            j = 0;
            r++;
        end
        col_cnt = j;
        row_cnt = r;
    endtask

    task automatic predict_drain();
        int       w;
        int       h;
        int       d;
        int       c;
        sem_win_t dw;
        logic     done;
        w = active_width();
        h = active_height();
        d = drain_col;
        if (row_cnt < h || d >= w) return;
        dw = '0;
        for (int dc = 0; dc < 3; dc++) begin
            c = d + dc - 1;
            if (c >= 0 && c < w) begin
                if (h >= 2) dw[dc] = upper_row[c];
                dw[3+dc] = middle_row[c];
            end
        end
        done = (d == w - 1);
        pending_edges.push_back(edge_of_window(dw, 1'b1, done));
        if (done) begin
            restart_frame();
        end else begin
            drain_col = d + 1;
        end
    endtask

    task automatic apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_IMAGE_WIDTH: begin
                width_reg = value[IWIDTH_W-1:0];
                restart_frame();
            end
            REG_IMAGE_HEIGHT: begin
                height_reg = value;
                restart_frame();
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        edge_result_t want;
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            restart_frame();
            pending_edges.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) apply_config(cfg_index, cfg_wdata);
            // Predict before popping so a result never overtakes its own expectation.
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_DRAIN) begin
                    predict_drain();
                end else begin
                    predict_pixel(s_tdata);
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending_edges.size() == 0) begin
                    $error("result with no expectation: tdata %h, tlast %b, tuser %b",
                           m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end else begin
                    want = pending_edges.pop_front();
                    compare_field("red_edge", want.red, m_tdata[7:0]);
                    compare_field("green_edge", want.green, m_tdata[15:8]);
                    compare_field("blue_edge", want.blue, m_tdata[23:16]);
                    compare_field("last_of_run", want.last_of_run, m_tlast);
                    compare_field("frame_done", want.frame_done, m_tuser);
                end
            end
        end
        outstanding = pending_edges.size();
    end

endmodule

### sim/tb_sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_rgb;
    import sem_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int SETTLE_CYCLES = 48;
    localparam int LONG_HOLD     = 500;
    localparam int RANDOM_ITEMS  = 1500;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    outstanding;
    int                    mismatches;

    bit gaps_on = 1'b1;
    bit long_hold_req;
    int chan_lo;
    int chan_spread;
    int random_items;

    sobel_edge_magnitude_rgb #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sobel_edge_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: random ready bursts, plus one long hold-off on request.
    initial begin : sink
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(logic cmd, logic [23:0] data);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] width_val, logic [CFG_DATA_W-1:0] height_val);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, width_val);
        write_reg(REG_IMAGE_HEIGHT, height_val);
    endtask

    // Spread 0 gives only black and white channels, which drives the clamp hard;
    // narrow spreads keep the gradients small enough to exercise the rounding.
    task automatic pick_style();
        case ($urandom_range(0, 3))
            0:       chan_spread = 0;
            1:       chan_spread = 7;
            2:       chan_spread = 40;
            default: chan_spread = 255;
        endcase
        chan_lo = $urandom_range(0, 255 - chan_spread);
    endtask

    function automatic logic [7:0] pick_chan();
        if (chan_spread == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'(chan_lo + $urandom_range(0, chan_spread));
    endfunction

    function automatic logic [23:0] random_pixel();
        return {pick_chan(), pick_chan(), pick_chan()};
    endfunction

    // Sends one frame of the given effective size. A frame cut short at stop_at
    // gets no drain; the next register write restarts the block.
    task automatic run_frame(int w, int h, bit noisy, int stop_at);
        int total;
        total = w * h;
        pick_style();
        for (int i = 0; i < total; i++) begin
            if (i == stop_at) return;
            if (noisy && $urandom_range(0, 19) == 0) send_item(CMD_DRAIN, 24'($urandom));
            if (noisy && $urandom_range(0, 99) == 0) wait_idle();
            send_item(CMD_PIXEL, random_pixel());
            random_items++;
        end
        if (noisy) repeat ($urandom_range(0, 2)) send_item(CMD_PIXEL, random_pixel());
        for (int i = 0; i < w; i++) begin
            send_item(CMD_DRAIN, 24'($urandom));
            random_items++;
        end
        if (noisy && $urandom_range(0, 3) == 0) send_item(CMD_DRAIN, 24'($urandom));
    endtask

    initial begin : stimulus
        int w;
        int h;
        int stop_at;
        int cur_w;
        int cur_h;
        bit frame_open;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_PIXEL;
        cfg_we    = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset geometry: one full row of 1024 and the start of the second row.
        run_frame(1024, 768, 1'b0, 1026);

        // 3x3 frame of extremes, with a drain before the frame is complete, a pixel
        // past the frame and a drain after the frame has finished.
        configure(3, 3);
        send_item(CMD_DRAIN, 24'hFFFFFF);
        for (int i = 0; i < 9; i++) begin
            send_item(CMD_PIXEL, (i % 3 == 0) ? 24'h000000 :
                                 (i % 3 == 1) ? 24'hFFFFFF : 24'hFF00FF);
        end
        send_item(CMD_PIXEL, 24'h00FF00);
        repeat (3) send_item(CMD_DRAIN, 24'h000000);
        send_item(CMD_DRAIN, 24'h000000);

        // Zero in both registers behaves as a 1x1 frame.
        configure(0, 0);
        send_item(CMD_PIXEL, 24'hFFFFFF);
        send_item(CMD_DRAIN, 24'hFFFFFF);

        // Writes to unused indexes must not disturb a frame in progress.
        configure(2, 2);
        send_item(CMD_PIXEL, 24'hFF0000);
        send_item(CMD_PIXEL, 24'h00FFFF);
        wait_idle();
        write_reg(REG_SPARE_LO, 13'h1FFF);
        write_reg(REG_SPARE_HI, 13'h0000);
        send_item(CMD_PIXEL, 24'h0000FF);
        send_item(CMD_PIXEL, 24'hFFFF00);
        repeat (2) send_item(CMD_DRAIN, 24'h000000);

        // Width above the line buffer depth is clipped to it.
        configure(13'h07FF, 2);
        run_frame(1024, 2, 1'b0, -1);
        // The width register drops the top two data bits; this is width 5.
        configure(13'h1805, 13'h1FFF);
        run_frame(5, 8191, 1'b1, 23);
        configure(1, 4096);
        run_frame(1, 4096, 1'b1, 9);
        configure(1, 3);
        run_frame(1, 3, 1'b1, -1);
        configure(7, 1);
        run_frame(7, 1, 1'b1, -1);

        // Long hold-off on the result side while the sender keeps offering items.
        configure(6, 5);
        long_hold_req = 1'b1;
        run_frame(6, 5, 1'b0, -1);

        random_items = 0;
        cur_w = 6;
        cur_h = 5;
        frame_open = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items > RANDOM_ITEMS * 4 / 5) gaps_on = 1'b0;
            if (frame_open || $urandom_range(0, 3) != 0) begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                configure(13'(w + ($urandom_range(0, 3) << 11)), 13'(h));
                cur_w = w;
                cur_h = h;
            end
            stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cur_w * cur_h - 1) : -1;
            run_frame(cur_w, cur_h, 1'b1, stop_at);
            frame_open = (stop_at >= 0);
        end

        gaps_on = 1'b0;
        wait_idle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
